>>> hw/rtl/fdss_pkg.sv
`timescale 1ns / 1ps
package fdss_pkg;

	localparam int ADDR_W = 21;
	localparam int IDX_W = 5;
	localparam int MASK_W = 12;
	localparam int IVL_W = 16;
	localparam int CFG_W = 16;

	localparam logic [IDX_W-1:0] FIRST_PICTURE = 5'd5;

	// input kinds
	localparam logic [1:0] KIND_TICK = 2'd0;
	localparam logic [1:0] KIND_SHOW = 2'd1;
	localparam logic [1:0] KIND_DISABLE = 2'd2;

	// result actions
	localparam logic [2:0] ACT_NONE = 3'd0;
	localparam logic [2:0] ACT_CMD = 3'd1;
	localparam logic [2:0] ACT_DATA = 3'd2;
	localparam logic [2:0] ACT_WINDOW = 3'd3;
	localparam logic [2:0] ACT_FLASH_READ = 3'd4;
	localparam logic [2:0] ACT_SEND = 3'd5;
	localparam logic [2:0] ACT_SAVE = 3'd6;

	// display bytes
	localparam logic [7:0] CMD_MADCTL = 8'h36;
	localparam logic [7:0] DATA_MADCTL = 8'h00;
	localparam logic [7:0] CMD_DISP_OFF = 8'h28;
	localparam logic [7:0] CMD_DISP_ON = 8'h29;

	// jobs queued between front and back
	localparam logic [2:0] JOB_INIT = 3'd0;
	localparam logic [2:0] JOB_READ = 3'd1;
	localparam logic [2:0] JOB_SEND = 3'd2;
	localparam logic [2:0] JOB_DISP_ON = 3'd3;
	localparam logic [2:0] JOB_SAVE = 3'd4;

	// config register indexes
	localparam logic REG_SWITCH_INTERVAL = 1'b0;
	localparam logic REG_SKIP_MASK = 1'b1;

	typedef struct packed {
		logic [1:0] kind;
		logic [IDX_W-1:0] pic_index;
		logic flash_done;
		logic send_done;
	} in_word_t;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] byte_value;
		logic [ADDR_W-1:0] flash_address;
		logic [IDX_W-1:0] current_index;
		logic flash_busy;
		logic last;
	} out_word_t;

	typedef struct packed {
		logic [2:0] jtype;
		logic [ADDR_W-1:0] addr;
		logic [IDX_W-1:0] index;
		logic busy;
	} job_t;

endpackage

>>> hw/rtl/fdss_front.sv
`timescale 1ns / 1ps
module fdss_front import fdss_pkg::*; #(
	parameter int CHUNK_BYTES = 9600,
	parameter int IMAGE_BYTES = 115200,
	parameter int SLOT_BYTES = 115200,
	parameter int LAST_PICTURE = 16
) (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input in_word_t in_data,
	input logic cfg_we,
	input logic cfg_index,
	input logic [CFG_W-1:0] cfg_wdata,
	output logic job_valid,
	output job_t job
);

	localparam int OFF_W = $clog2(IMAGE_BYTES + CHUNK_BYTES);
	localparam int SLOT_W = $clog2(SLOT_BYTES + 1);
	localparam int PROD_W = (IDX_W + SLOT_W > ADDR_W) ? IDX_W + SLOT_W : ADDR_W;

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_INIT = 3'd1;
	localparam logic [2:0] PH_READ = 3'd2;
	localparam logic [2:0] PH_RWAIT = 3'd3;
	localparam logic [2:0] PH_WRITE = 3'd4;
	localparam logic [2:0] PH_WWAIT = 3'd5;

	logic [2:0] phase_q, phase_d;
	logic [IDX_W-1:0] pic_q, pic_d;
	logic [ADDR_W-1:0] slot_base_q, slot_base_d;
	logic [OFF_W-1:0] offset_q, offset_d;
	logic upd_en_q, upd_en_d;
	logic armed_q, armed_d;
	logic [IVL_W-1:0] delay_q, delay_d;
	logic busy_q, busy_d;
	logic [IVL_W-1:0] interval_q;
	logic [MASK_W-1:0] mask_q;

	logic [IDX_W-1:0] show_idx;
	logic [IDX_W-1:0] show_idx_m1;
	logic [PROD_W-1:0] slot_prod;
	logic [OFF_W-1:0] offset_sum;
	logic [IVL_W-1:0] delay_inc;
	logic [IDX_W-1:0] mask_pos;
	logic pic_masked;

	function automatic logic [IDX_W-1:0] next_picture(input logic [IDX_W-1:0] p);
		logic [IDX_W:0] n;
		n = {1'b0, p} + 1'b1;
		if (n > (IDX_W+1)'(LAST_PICTURE)) begin
			n = {1'b0, FIRST_PICTURE};
		end
		return n[IDX_W-1:0];
	endfunction

	// auto restart reuses the current picture, a show request takes the new index
	assign show_idx = (in_data.kind == KIND_SHOW) ? in_data.pic_index : pic_q;
	assign show_idx_m1 = show_idx - 1'b1;
	assign slot_prod = PROD_W'(show_idx_m1) * PROD_W'(SLOT_BYTES);

	assign offset_sum = offset_q + OFF_W'(CHUNK_BYTES);
	assign delay_inc = (delay_q == {IVL_W{1'b1}}) ? delay_q : delay_q + 1'b1;
	assign mask_pos = pic_q - FIRST_PICTURE;
	// mask only covers pictures 5..16
	assign pic_masked = (pic_q >= FIRST_PICTURE) && (mask_pos < IDX_W'(MASK_W))
		&& mask_q[mask_pos[$clog2(MASK_W)-1:0]];

	always_comb begin
		phase_d = phase_q;
		pic_d = pic_q;
		slot_base_d = slot_base_q;
		offset_d = offset_q;
		upd_en_d = upd_en_q;
		armed_d = armed_q;
		delay_d = delay_q;
		busy_d = busy_q;
		job_valid = 1'b0;
		job.jtype = JOB_INIT;
		job.addr = '0;
		if (accept) begin
			unique case (in_data.kind)
				KIND_TICK: begin
					if (armed_q && upd_en_q) begin
						unique case (phase_q)
							PH_INIT: begin
								job_valid = 1'b1;
								job.jtype = JOB_INIT;
								phase_d = PH_READ;
							end
							PH_READ: begin
								busy_d = 1'b1;
								job_valid = 1'b1;
								job.jtype = JOB_READ;
								job.addr = slot_base_q + ADDR_W'(offset_q);
								phase_d = PH_RWAIT;
							end
							PH_RWAIT: begin
								if (in_data.flash_done) begin
									busy_d = 1'b0;
									phase_d = PH_WRITE;
								end
							end
							PH_WRITE: begin
								job_valid = 1'b1;
								job.jtype = JOB_SEND;
								phase_d = PH_WWAIT;
							end
							PH_WWAIT: begin
								if (in_data.send_done) begin
									if (offset_sum >= OFF_W'(IMAGE_BYTES)) begin
										job_valid = 1'b1;
										job.jtype = JOB_DISP_ON;
										offset_d = '0;
										if (interval_q != '0) begin
											pic_d = next_picture(pic_q);
										end
										phase_d = PH_IDLE;
									end else begin
										offset_d = offset_sum;
										phase_d = PH_READ;
									end
								end
							end
							default: begin
								if (interval_q != '0) begin
									if (!pic_masked) begin
										delay_d = delay_inc;
										if (delay_inc >= interval_q) begin
											delay_d = '0;
											slot_base_d = slot_prod[ADDR_W-1:0];
											offset_d = '0;
											upd_en_d = 1'b1;
											armed_d = 1'b1;
											phase_d = PH_INIT;
											job_valid = 1'b1;
											job.jtype = JOB_SAVE;
										end
									end else begin
										pic_d = next_picture(pic_q);
									end
								end
							end
						endcase
					end
				end
				KIND_SHOW: begin
					pic_d = in_data.pic_index;
					slot_base_d = slot_prod[ADDR_W-1:0];
					offset_d = '0;
					upd_en_d = 1'b1;
					armed_d = 1'b1;
					phase_d = PH_INIT;
				end
				KIND_DISABLE: begin
					upd_en_d = 1'b0;
				end
				default: begin
				end
			endcase
		end
		job.index = pic_d;
		job.busy = busy_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pic_q <= FIRST_PICTURE;
			slot_base_q <= '0;
			offset_q <= '0;
			upd_en_q <= 1'b0;
			armed_q <= 1'b0;
			delay_q <= '0;
			busy_q <= 1'b0;
			interval_q <= '0;
			mask_q <= '0;
		end else begin
			phase_q <= phase_d;
			pic_q <= pic_d;
			slot_base_q <= slot_base_d;
			offset_q <= offset_d;
			upd_en_q <= upd_en_d;
			armed_q <= armed_d;
			delay_q <= delay_d;
			busy_q <= busy_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_SWITCH_INTERVAL: interval_q <= cfg_wdata[IVL_W-1:0];
					REG_SKIP_MASK: mask_q <= cfg_wdata[MASK_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

endmodule

>>> hw/rtl/fdss_queue.sv
`timescale 1ns / 1ps
module fdss_queue import fdss_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input job_t push_job,
	input logic pop,
	output logic full,
	output logic empty,
	output job_t head
);

	job_t mem_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] cnt_q;

	assign full = cnt_q[1];
	assign empty = (cnt_q == 2'd0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

>>> hw/rtl/fdss_back.sv
`timescale 1ns / 1ps
module fdss_back import fdss_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic empty,
	input job_t head,
	output logic pop,
	output logic out_valid,
	input logic out_stall,
	output out_word_t out_data
);

	logic [1:0] seq_q;
	logic out_valid_q;
	out_word_t out_q;
	out_word_t word;
	logic load;

	// expand the head job into result words, init gives four of them
	always_comb begin
		word.action = ACT_NONE;
		word.byte_value = '0;
		word.flash_address = '0;
		word.current_index = head.index;
		word.flash_busy = head.busy;
		word.last = 1'b1;
		unique case (head.jtype)
			JOB_INIT: begin
				word.last = (seq_q == 2'd3);
				unique case (seq_q)
					2'd0: begin
						word.action = ACT_CMD;
						word.byte_value = CMD_MADCTL;
					end
					2'd1: begin
						word.action = ACT_DATA;
						word.byte_value = DATA_MADCTL;
					end
					2'd2: begin
						word.action = ACT_CMD;
						word.byte_value = CMD_DISP_OFF;
					end
					default: word.action = ACT_WINDOW;
				endcase
			end
			JOB_READ: begin
				word.action = ACT_FLASH_READ;
				word.flash_address = head.addr;
			end
			JOB_SEND: word.action = ACT_SEND;
			JOB_DISP_ON: begin
				word.action = ACT_CMD;
				word.byte_value = CMD_DISP_ON;
			end
			default: word.action = ACT_SAVE;
		endcase
	end

	assign load = !out_valid_q || !out_stall;
	assign pop = load && !empty && word.last;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			out_q <= word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= 2'd0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= !empty;
			if (!empty) begin
				seq_q <= word.last ? 2'd0 : seq_q + 2'd1;
			end
		end
	end

endmodule

>>> hw/rtl/flash_to_display_slideshow_sequencer.sv
`timescale 1ns / 1ps
// the first result word of an input goes through the job queue, then the out_data register
// throughput: one input word per cycle while the two-entry job queue has room
// the output side delivers one result word per cycle while out_stall is low;
// an init tick gives four words, so a stream of such ticks is paced by the back end
// reset: arst_n clears all sequencer state, config and queue at once; no clearing pass
module flash_to_display_slideshow_sequencer import fdss_pkg::*; #(
	parameter int CHUNK_BYTES = 9600,
	parameter int IMAGE_BYTES = 115200,
	parameter int SLOT_BYTES = 115200,
	parameter int LAST_PICTURE = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input in_word_t in_data,
	output logic out_valid,
	input logic out_stall,
	output out_word_t out_data,
	input logic cfg_we,
	input logic cfg_index,
	input logic [CFG_W-1:0] cfg_wdata
);

	logic accept;
	logic job_valid;
	job_t job;
	logic q_full;
	logic q_empty;
	logic q_pop;
	job_t q_head;

	assign in_stall = q_full;
	assign accept = in_valid && !q_full;

	fdss_front #(
		.CHUNK_BYTES(CHUNK_BYTES),
		.IMAGE_BYTES(IMAGE_BYTES),
		.SLOT_BYTES(SLOT_BYTES),
		.LAST_PICTURE(LAST_PICTURE)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.in_data(in_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.job_valid(job_valid),
		.job(job)
	);

	fdss_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(job_valid),
		.push_job(job),
		.pop(q_pop),
		.full(q_full),
		.empty(q_empty),
		.head(q_head)
	);

	fdss_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.empty(q_empty),
		.head(q_head),
		.pop(q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

endmodule

>>> hw/rtl/fdss_checker.sv
`timescale 1ns / 1ps
module fdss_checker import fdss_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input out_word_t out_data
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	a_action_real: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.action != ACT_NONE && out_data.action <= ACT_SAVE)
		else $error("result word without an action");

	a_byte_only_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.action != ACT_CMD && out_data.action != ACT_DATA
		|-> out_data.byte_value == '0)
		else $error("byte value on a non-byte action");

	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.action == ACT_FLASH_READ |-> out_data.flash_busy)
		else $error("flash read issued without busy");

	a_window_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.action == ACT_WINDOW |-> out_data.last
		&& out_data.flash_address == '0)
		else $error("set window is not the closing word of init");

endmodule

bind flash_to_display_slideshow_sequencer fdss_checker u_fdss_checker (.*);

>>> dv/tb_flash_to_display_slideshow_sequencer.sv
`timescale 1ns / 1ps
module tb_flash_to_display_slideshow_sequencer;
	import fdss_pkg::*;

	localparam int CHUNK_BYTES = 9600;
	localparam int IMAGE_BYTES = 115200;
	localparam int SLOT_BYTES = 115200;
	localparam int LAST_PICTURE = 16;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	typedef enum logic [2:0] {
		PH_IDLE, PH_INIT, PH_READ, PH_RWAIT, PH_WRITE, PH_WWAIT
	} show_phase_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_word_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_word_t out_data;
	logic cfg_we = 1'b0;
	logic cfg_index = REG_SWITCH_INTERVAL;
	logic [CFG_W-1:0] cfg_wdata = '0;

	flash_to_display_slideshow_sequencer uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// sequencer model state
	logic [IVL_W-1:0] sw_interval = '0;
	logic [MASK_W-1:0] skip_bits = '0;
	show_phase_t seq_phase = PH_IDLE;
	logic [IDX_W-1:0] pic_no = FIRST_PICTURE;
	logic [ADDR_W-1:0] slot_base_q = '0;
	int chunk_off = 0;
	bit upd_en = 1'b0;
	bit show_armed = 1'b0;
	logic [IVL_W-1:0] idle_ticks = '0;
	bit rd_busy = 1'b0;

	out_word_t step_words[$];
	out_word_t pending_actions[$];
	in_word_t stim_words[$];

	int pushed_cnt = 0;
	int taken_cnt = 0;
	int word_no = 0;
	int err_cnt = 0;
	int send_gap = 0;
	int stall_left = 0;
	bit no_idle = 1'b0;

	task automatic flag_error(string msg);
		$display("%0t mismatch: %s", $time, msg);
		err_cnt++;
	endtask

	task automatic check_field(string name, int got, int want);
		if (got != want)
			flag_error($sformatf("word %0d %s got %0h want %0h", word_no, name, got, want));
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		else if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic void note_word(logic [2:0] act, logic [7:0] b, logic [ADDR_W-1:0] addr);
		out_word_t w;
		w = '0;
		w.action = act;
		w.byte_value = b;
		w.flash_address = addr;
		step_words.push_back(w);
	endfunction

	function automatic void begin_show(logic [IDX_W-1:0] idx);
		logic [IDX_W-1:0] slot;
		longint prod;
		// slot wraps mod 32, so index 0 gives slot 31
		slot = idx - 5'd1;
		prod = longint'(slot) * SLOT_BYTES;
		pic_no = idx;
		slot_base_q = prod[ADDR_W-1:0];
		chunk_off = 0;
		upd_en = 1'b1;
		seq_phase = PH_INIT;
		show_armed = 1'b1;
	endfunction

	function automatic void next_picture();
		int nxt;
		nxt = pic_no + 1;
		if (nxt > LAST_PICTURE)
			nxt = FIRST_PICTURE;
		pic_no = nxt[IDX_W-1:0];
	endfunction

	function automatic void step_tick(bit fdone, bit sdone);
		int sum;
		int bitpos;
		bit masked;
		case (seq_phase)
			PH_INIT: begin
				note_word(ACT_CMD, CMD_MADCTL, '0);
				note_word(ACT_DATA, DATA_MADCTL, '0);
				note_word(ACT_CMD, CMD_DISP_OFF, '0);
				note_word(ACT_WINDOW, 8'h00, '0);
				seq_phase = PH_READ;
			end
			PH_READ: begin
				rd_busy = 1'b1;
				sum = int'(slot_base_q) + chunk_off;
				note_word(ACT_FLASH_READ, 8'h00, sum[ADDR_W-1:0]);
				seq_phase = PH_RWAIT;
			end
			PH_RWAIT: begin
				if (fdone) begin
					rd_busy = 1'b0;
					seq_phase = PH_WRITE;
				end
			end
			PH_WRITE: begin
				note_word(ACT_SEND, 8'h00, '0);
				seq_phase = PH_WWAIT;
			end
			PH_WWAIT: begin
				if (sdone) begin
					chunk_off += CHUNK_BYTES;
					if (chunk_off >= IMAGE_BYTES) begin
						note_word(ACT_CMD, CMD_DISP_ON, '0);
						chunk_off = 0;
						if (sw_interval != 0)
							next_picture();
						seq_phase = PH_IDLE;
					end else begin
						seq_phase = PH_READ;
					end
				end
			end
			default: begin
				if (sw_interval != 0) begin
					masked = 1'b0;
					// pictures outside 5..16 have no mask bit
					if (pic_no >= 5 && pic_no <= 16) begin
						bitpos = pic_no - 5;
						masked = skip_bits[bitpos];
					end
					if (!masked) begin
						if (idle_ticks != 16'hFFFF)
							idle_ticks++;
						if (idle_ticks >= sw_interval) begin
							idle_ticks = '0;
							begin_show(pic_no);
							note_word(ACT_SAVE, 8'h00, '0);
						end
					end else begin
						next_picture();
					end
				end
			end
		endcase
	endfunction

	function automatic void predict_actions(in_word_t w);
		step_words.delete();
		case (w.kind)
			KIND_TICK: begin
				if (show_armed && upd_en)
					step_tick(w.flash_done, w.send_done);
			end
			KIND_SHOW: begin_show(w.pic_index);
			KIND_DISABLE: upd_en = 1'b0;
			default: ;
		endcase
		foreach (step_words[k]) begin
			step_words[k].current_index = pic_no;
			step_words[k].flash_busy = rd_busy;
			step_words[k].last = (k == step_words.size() - 1);
			pending_actions.push_back(step_words[k]);
		end
	endfunction

	// sender
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_actions(in_data);
				taken_cnt++;
			end
			if (!in_valid || !in_stall) begin
				if (send_gap != 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (stim_words.size() != 0) begin
					in_data <= stim_words.pop_front();
					in_valid <= 1'b1;
					send_gap = no_idle ? 0 : gap_len();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk) begin : watch_out
		out_word_t want_w;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_actions.size() == 0) begin
					flag_error($sformatf("word %0d arrived with none expected: %h", word_no,
						out_data));
				end else begin
					want_w = pending_actions.pop_front();
					check_field("action", int'(out_data.action), int'(want_w.action));
					check_field("byte_value", int'(out_data.byte_value),
						int'(want_w.byte_value));
					check_field("flash_address", int'(out_data.flash_address),
						int'(want_w.flash_address));
					check_field("current_index", int'(out_data.current_index),
						int'(want_w.current_index));
					check_field("flash_busy", int'(out_data.flash_busy),
						int'(want_w.flash_busy));
					check_field("last", int'(out_data.last), int'(want_w.last));
				end
				word_no++;
			end
			if (stall_left != 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				if (!no_idle && $urandom_range(0, 7) == 0)
					stall_left = gap_len();
			end
		end
	end

	function automatic in_word_t tick_word(bit f, bit s);
		in_word_t w;
		w = '0;
		w.kind = KIND_TICK;
		w.pic_index = IDX_W'($urandom);
		w.flash_done = f;
		w.send_done = s;
		return w;
	endfunction

	function automatic in_word_t show_word(logic [IDX_W-1:0] idx);
		in_word_t w;
		w = '0;
		w.kind = KIND_SHOW;
		w.pic_index = idx;
		w.flash_done = 1'($urandom);
		w.send_done = 1'($urandom);
		return w;
	endfunction

	task automatic push_item(in_word_t w);
		stim_words.push_back(w);
		pushed_cnt++;
	endtask

	function automatic logic [IDX_W-1:0] pick_picture();
		if ($urandom_range(0, 4) == 0)
			return IDX_W'($urandom);
		return IDX_W'($urandom_range(1, LAST_PICTURE));
	endfunction

	task automatic push_random_item();
		in_word_t w;
		int r;
		r = $urandom_range(0, 99);
		if (r < 93) begin
			push_item(tick_word($urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0));
		end else if (r < 96) begin
			push_item(show_word(pick_picture()));
		end else if (r < 98) begin
			// disable, a tick that does nothing, then a fresh show
			w = tick_word(1'($urandom), 1'($urandom));
			w.kind = KIND_DISABLE;
			push_item(w);
			push_item(tick_word(1'b1, 1'b1));
			push_item(show_word(pick_picture()));
		end else begin
			w = tick_word(1'($urandom), 1'($urandom));
			w.kind = KIND_UNUSED;
			push_item(w);
		end
	endtask

	task automatic set_config(logic [CFG_W-1:0] ivl, logic [CFG_W-1:0] mask);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_SWITCH_INTERVAL;
		cfg_wdata <= ivl;
		sw_interval = ivl;
		@(posedge clk);
		cfg_index <= REG_SKIP_MASK;
		cfg_wdata <= mask;
		skip_bits = mask[MASK_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (taken_cnt != pushed_cnt || pending_actions.size() != 0)
			@(posedge clk);
		// a word with no result may still be in the pipe
		repeat (16) @(posedge clk);
	endtask

	task automatic run_phase(logic [CFG_W-1:0] ivl, logic [CFG_W-1:0] mask, bit quiet, int n);
		set_config(ivl, mask);
		no_idle = quiet;
		push_item(show_word(pick_picture()));
		repeat (n - 1) push_random_item();
		drain();
	endtask

	initial begin : stimulus
		in_word_t w;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		set_config(16'd0, 16'd0);

		// a tick before any show, an unused kind, a disable
		push_item(tick_word(1'b1, 1'b1));
		w = tick_word(1'b1, 1'b1);
		w.kind = KIND_UNUSED;
		w.pic_index = 5'h1F;
		push_item(w);
		w.kind = KIND_DISABLE;
		push_item(w);
		// first slot, one chunk with both wait states held off once
		push_item(show_word(5'd1));
		push_item(tick_word(1'b0, 1'b0));
		push_item(tick_word(1'b0, 1'b0));
		push_item(tick_word(1'b0, 1'b0));
		push_item(tick_word(1'b1, 1'b0));
		push_item(tick_word(1'b0, 1'b0));
		push_item(tick_word(1'b0, 1'b0));
		push_item(tick_word(1'b0, 1'b1));
		// disabled tick is ignored
		w.kind = KIND_DISABLE;
		push_item(w);
		push_item(tick_word(1'b1, 1'b1));
		// last slot, then indexes outside the valid range
		push_item(show_word(5'd16));
		push_item(tick_word(1'b1, 1'b1));
		push_item(tick_word(1'b1, 1'b1));
		push_item(show_word(5'd0));
		push_item(tick_word(1'b1, 1'b1));
		push_item(tick_word(1'b1, 1'b1));
		push_item(show_word(5'd31));
		push_item(tick_word(1'b1, 1'b1));
		push_item(tick_word(1'b1, 1'b1));
		push_item(show_word(5'd17));
		push_item(tick_word(1'b1, 1'b1));
		push_item(tick_word(1'b1, 1'b1));
		drain();

		run_phase(16'd0, 16'h0000, 1'b1, 70);
		run_phase(16'd1, CFG_W'($urandom), 1'b0, 60);
		run_phase(16'hFFFF, 16'hFFFF, 1'b0, 40);
		run_phase(CFG_W'($urandom_range(2, 4)), CFG_W'($urandom_range(0, 16'h0FFF)), 1'b0,
			60);
		run_phase(16'd1, 16'h0000, 1'b1, 30);

		if (err_cnt == 0)
			$display("tb_flash_to_display_slideshow_sequencer: clean");
		else
			$display("tb_flash_to_display_slideshow_sequencer: errors");
		$finish;
	end

	initial begin : watchdog
		#5000000;
		$display("tb_flash_to_display_slideshow_sequencer: errors");
		$finish;
	end

endmodule

>>> flash_to_display_slideshow_sequencer.f
hw/rtl/fdss_pkg.sv
hw/rtl/fdss_front.sv
hw/rtl/fdss_queue.sv
hw/rtl/fdss_back.sv
hw/rtl/flash_to_display_slideshow_sequencer.sv
hw/rtl/fdss_checker.sv
dv/tb_flash_to_display_slideshow_sequencer.sv
